// ===== sv/vad_pkg.sv =====
package vad_pkg;

  // Extra fraction bits carried by the CORDIC x/y datapath
  localparam int GUARD_BITS  = 24;
  // Fraction bits of the angle accumulator (units of 2^-20 degree)
  localparam int ZF_BITS     = 20;
  // Depth of the arctangent table
  localparam int MAX_STAGES  = 24;
  // Angle accumulator width: holds +/- 360 deg at ZF_BITS fraction bits
  localparam int ZW          = 32;
  // Width of the delivered angle field
  localparam int ANGLE_WIDTH = 16;

  typedef logic signed [ZW-1:0] angle_acc_t;

  localparam angle_acc_t DEG_90  = angle_acc_t'(90 <<< ZF_BITS);
  localparam angle_acc_t DEG_180 = angle_acc_t'(180 <<< ZF_BITS);
  localparam angle_acc_t DEG_270 = angle_acc_t'(270 <<< ZF_BITS);
  localparam angle_acc_t DEG_360 = angle_acc_t'(360 <<< ZF_BITS);

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic special;  // angle already exact in the accumulator, skip rotations
    logic neg_x;    // vector was negated, add half a turn at the end
    logic dy_pos;   // original dy above zero
  } vad_ctrl_t;

  // round(atan(2^-i) * 180/pi * 2^20)
  function automatic int atan_deg(input int idx);
    case (idx)
      0:       atan_deg = 47185920;
      1:       atan_deg = 27855475;
      2:       atan_deg = 14718068;
      3:       atan_deg = 7471121;
      4:       atan_deg = 3750058;
      5:       atan_deg = 1876857;
      6:       atan_deg = 938658;
      7:       atan_deg = 469357;
      8:       atan_deg = 234682;
      9:       atan_deg = 117342;
      10:      atan_deg = 58671;
      11:      atan_deg = 29335;
      12:      atan_deg = 14668;
      13:      atan_deg = 7334;
      14:      atan_deg = 3667;
      15:      atan_deg = 1833;
      16:      atan_deg = 917;
      17:      atan_deg = 458;
      18:      atan_deg = 229;
      19:      atan_deg = 115;
      20:      atan_deg = 57;
      21:      atan_deg = 29;
      22:      atan_deg = 14;
      23:      atan_deg = 7;
      default: atan_deg = 0;
    endcase
  endfunction

endpackage

// ===== sv/vector_angle_degrees_core.sv =====
// Direction of a screen-space vector, in degrees.
//
// Input: drive start_x/start_y/end_x/end_y on the in_ ports and raise start;
// a transfer happens at every rising edge with start high and busy low.
// busy is low whenever reset is released, so one item may enter each cycle.
// Output: out_valid is high for exactly one cycle with the angle on
// out_angle_deg (unsigned Q9.7 degrees, counterclockwise, y grows down).
// The receiver cannot stall; each result transfers in its strobe cycle.
// Pipeline: one fold stage, one register per CORDIC iteration, one stage for
// the quadrant fix-up and one for rounding.
// Throughput: one item per clock, set by the fully unrolled CORDIC pipe.
// Reset (synchronous, rst_n low) clears every valid bit in the pipe, so items
// in flight are dropped; busy is high while reset is held.
// Vertical vectors give exactly 90 or 270, horizontal ones 0 or 180, a zero
// vector 0, and a result that rounds to a full turn wraps to 0.
module vector_angle_degrees_core
  import vad_pkg::*;
#(
  parameter int COORD_WIDTH     = 16,
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  output logic                          out_valid,
  output logic [ANGLE_WIDTH-1:0]        out_angle_deg
);

  // Differences need one more bit than the coordinates
  localparam int DW   = COORD_WIDTH + 1;
  // CORDIC gain times sqrt(2) stays below 4: two bits of headroom
  localparam int XW   = DW + GUARD_BITS + 2;
  localparam int HW   = XW - GUARD_BITS;
  localparam int SH   = ZF_BITS - ANGLE_FRAC_BITS;
  localparam int LAT  = CORDIC_STAGES + 3;
  localparam angle_acc_t HALF = angle_acc_t'(1 <<< (SH - 1));
  localparam angle_acc_t FULL = angle_acc_t'(360 <<< ANGLE_FRAC_BITS);

  // ---------------------------------------------------------------
  // Fold stage: form the vector, flag exact cases, fold left half
  // ---------------------------------------------------------------
  logic signed [DW-1:0] dx, dy, ax, ay;
  logic signed [HW-1:0] ax_e, ay_e;
  logic                 accept;
  vad_ctrl_t            ctrl0_nxt;
  angle_acc_t           z0_nxt;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  assign dx = {in_end_x[COORD_WIDTH-1], in_end_x}
            - {in_start_x[COORD_WIDTH-1], in_start_x};
  // Flip y so that up is positive
  assign dy = {in_start_y[COORD_WIDTH-1], in_start_y}
            - {in_end_y[COORD_WIDTH-1], in_end_y};

  assign ax   = dx[DW-1] ? -dx : dx;
  assign ay   = dx[DW-1] ? -dy : dy;
  assign ax_e = {{(HW-DW){ax[DW-1]}}, ax};
  assign ay_e = {{(HW-DW){ay[DW-1]}}, ay};

  always_comb begin
    ctrl0_nxt.valid   = accept;
    ctrl0_nxt.neg_x   = dx[DW-1];
    ctrl0_nxt.dy_pos  = ~dy[DW-1] && (dy != '0);
    ctrl0_nxt.special = (dx == '0) || (dy == '0);
    z0_nxt            = '0;
    if (dx == '0) begin
      // straight up, straight down, or no vector at all
      if (ctrl0_nxt.dy_pos) begin
        z0_nxt = DEG_90;
      end else if (dy != '0) begin
        z0_nxt = DEG_270;
      end
    end else if (dy == '0) begin
      if (dx[DW-1]) begin
        z0_nxt = DEG_180;
      end
    end
  end

  vad_ctrl_t            ctrl_s [0:CORDIC_STAGES];
  logic signed [XW-1:0] x_s    [0:CORDIC_STAGES];
  logic signed [XW-1:0] y_s    [0:CORDIC_STAGES];
  angle_acc_t           z_s    [0:CORDIC_STAGES];

  vad_ctrl_t            ctrl0_r;
  logic signed [XW-1:0] x0_r, y0_r;
  angle_acc_t           z0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl0_r.valid <= 1'b0;
    end else begin
      ctrl0_r <= ctrl0_nxt;
    end
  end

  // Scale the folded vector up by the guard bits
  always_ff @(posedge clk) begin
    x0_r <= {ax_e, {GUARD_BITS{1'b0}}};
    y0_r <= {ay_e, {GUARD_BITS{1'b0}}};
    z0_r <= z0_nxt;
  end

  assign ctrl_s[0] = ctrl0_r;
  assign x_s[0]    = x0_r;
  assign y_s[0]    = y0_r;
  assign z_s[0]    = z0_r;

  // ---------------------------------------------------------------
  // CORDIC vectoring: one registered iteration per stage
  // ---------------------------------------------------------------
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    vad_cordic_stage #(
      .XW    (XW),
      .SHIFT (g),
      .ATAN  (atan_deg(g))
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl_i (ctrl_s[g]),
      .x_i    (x_s[g]),
      .y_i    (y_s[g]),
      .z_i    (z_s[g]),
      .ctrl_o (ctrl_s[g+1]),
      .x_o    (x_s[g+1]),
      .y_o    (y_s[g+1]),
      .z_o    (z_s[g+1])
    );
  end

  // ---------------------------------------------------------------
  // Quadrant fix-up: bring the residue angle into [0, 360)
  // ---------------------------------------------------------------
  vad_ctrl_t  ctrl_l;
  angle_acc_t z_l, total_nxt, wrap4, total_r;
  logic       tvalid_r;

  assign ctrl_l = ctrl_s[CORDIC_STAGES];
  assign z_l    = z_s[CORDIC_STAGES];
  assign wrap4  = z_l + DEG_360;

  always_comb begin
    if (ctrl_l.special) begin
      total_nxt = z_l;
    end else if (ctrl_l.neg_x) begin
      total_nxt = DEG_180 + z_l;
    end else if (ctrl_l.dy_pos) begin
      // clamp a small undershoot in the first quadrant
      total_nxt = z_l[ZW-1] ? '0 : z_l;
    end else begin
      total_nxt = wrap4[ZW-1] ? '0 : wrap4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= 1'b0;
    end else begin
      tvalid_r <= ctrl_l.valid;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
  end

  // ---------------------------------------------------------------
  // Round half up to the output grid and wrap a full turn to zero
  // ---------------------------------------------------------------
  angle_acc_t                 rounded, q_nxt;
  logic [ANGLE_WIDTH-1:0]     angle_r;
  logic                       out_valid_r;

  assign rounded = (total_r + HALF) >>> SH;
  assign q_nxt   = (rounded >= FULL) ? (rounded - FULL) : rounded;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= q_nxt[ANGLE_WIDTH-1:0];
  end

  assign out_valid     = out_valid_r;
  assign out_angle_deg = angle_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // Every strobe comes from a matching input transfer at the pipe's input
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching input transfer");

  // The wrap keeps the angle below a full turn
  a_below_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (angle_acc_t'(out_angle_deg) < FULL))
    else $error("angle at or above a full turn");

  // A vector pointing straight up comes out as exactly 90 degrees
  a_straight_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(accept && (in_end_x == in_start_x)
                        && (in_start_y > in_end_y), LAT))
    |-> (out_angle_deg == ANGLE_WIDTH'(90 <<< ANGLE_FRAC_BITS)))
    else $error("vertical vector did not give exactly 90 degrees");

endmodule

// ===== sv/vad_cordic_stage.sv =====
module vad_cordic_stage
  import vad_pkg::*;
#(
  parameter int XW    = 43,
  parameter int SHIFT = 0,
  parameter int ATAN  = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vad_ctrl_t            ctrl_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  angle_acc_t           z_i,
  output vad_ctrl_t            ctrl_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output angle_acc_t           z_o
);

  vad_ctrl_t            ctrl_r;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt;
  angle_acc_t           z_r, z_nxt;
  logic signed [XW-1:0] xs, ys;

  // Arithmetic shift floors toward minus infinity
  assign xs = x_i >>> SHIFT;
  assign ys = y_i >>> SHIFT;

  always_comb begin
    if (ctrl_i.special) begin
      x_nxt = x_i;
      y_nxt = y_i;
      z_nxt = z_i;
    end else if (!y_i[XW-1]) begin
      // rotate clockwise
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + angle_acc_t'(ATAN);
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - angle_acc_t'(ATAN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.valid <= 1'b0;
    end else begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign ctrl_o = ctrl_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;

endmodule
